### sv/dad_pkg.sv
// Shared types, constants and the flag normalization table for the AVP deframer.
// Used by dad_step and diameter_avp_deframer_core; depends on nothing else.
`timescale 1ns / 1ps

package dad_pkg;

  // Largest buffer handled; bytes beyond it are dropped until the final byte.
  localparam int MAX_BUFFER_BYTES = 65536;
  // Wide enough to hold MAX_BUFFER_BYTES itself.
  localparam int OFS_W = $clog2(MAX_BUFFER_BYTES + 1);
  // Compare width for lengths: a 24-bit length plus padding and header.
  localparam int CMP_W = 25;

  localparam logic [7:0] VENDOR_BIT = 8'h80;
  localparam int HDR_STD = 8;
  localparam int HDR_VND = 12;
  // Length checks run once this many bytes of an AVP are in.
  localparam int CHECK_AT = 12;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT_HDR  = 3'd1,
    ST_ZERO_LEN   = 3'd2,
    ST_OVERRUN    = 3'd3,
    ST_EMPTY_DATA = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dad_in_t;

  typedef struct packed {
    logic        has_avp;
    logic [31:0] attr_code;
    logic [7:0]  attr_flags;
    logic [31:0] vendor_id;
    logic [15:0] data_offset;
    logic [23:0] data_len;
    logic [2:0]  status;
    logic        buffer_end;
  } dad_out_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [OFS_W-1:0] boff;     // bytes of the buffer consumed
    logic [15:0]      start;    // offset of the current AVP, low bits
    logic [OFS_W-1:0] nbytes;   // bytes of the current AVP seen
    logic [31:0]      code;
    logic [7:0]       flags;
    logic [23:0]      len;
    logic [31:0]      vendor;
    status_t          err;
  } dad_state_t;

  // Per-code flag normalization for well-known base protocol AVPs.
  function automatic logic [7:0] norm_flags(input logic [31:0] code, input logic [7:0] f);
    logic [7:0] r;
    case (code)
      32'd1, 32'd25, 32'd27, 32'd257, 32'd258, 32'd262, 32'd263, 32'd264, 32'd265,
      32'd266, 32'd268, 32'd270, 32'd276, 32'd278, 32'd283, 32'd291, 32'd293,
      32'd296: begin
        r = 8'h40 | (f & 8'h20);
      end
      32'd33: begin
        r = 8'h40;
      end
      32'd269: begin
        r = 8'h00;
      end
      32'd281: begin
        r = f & 8'h20;
      end
      default: begin
        r = f;
      end
    endcase
    return r;
  endfunction

endpackage

### sv/dad_step.sv
// Next-state and result logic for one buffer byte of the AVP deframer.
// Purely combinational; uses dad_pkg types, constants and norm_flags.
`timescale 1ns / 1ps

module dad_step (
  input  dad_pkg::dad_state_t cur,
  input  dad_pkg::dad_in_t    item,
  output dad_pkg::dad_state_t nxt,
  output dad_pkg::dad_out_t   res,
  output logic                res_valid
);

  logic [dad_pkg::OFS_W-1:0] n1;
  logic [dad_pkg::CMP_W-1:0] n1c;
  logic [dad_pkg::CMP_W-1:0] lenc;
  logic [dad_pkg::CMP_W-1:0] hdr;
  logic [dad_pkg::CMP_W-1:0] done_at;
  logic [dad_pkg::CMP_W-1:0] pend;
  logic [dad_pkg::CMP_W-1:0] nbc;
  logic [dad_pkg::CMP_W-1:0] nlenc;
  logic [23:0]               dlen;
  logic                      emit;
  logic                      active;

  always_comb begin
    nxt     = cur;
    res     = '0;
    emit    = 1'b0;
    n1      = cur.nbytes + 1'b1;
    n1c     = dad_pkg::CMP_W'(n1);
    lenc    = dad_pkg::CMP_W'(cur.len);
    hdr     = ((cur.flags & dad_pkg::VENDOR_BIT) != 8'h00) ?
              dad_pkg::CMP_W'(dad_pkg::HDR_VND) : dad_pkg::CMP_W'(dad_pkg::HDR_STD);
    dlen    = cur.len - hdr[23:0];
    done_at = (lenc > dad_pkg::CMP_W'(dad_pkg::CHECK_AT)) ?
              lenc : dad_pkg::CMP_W'(dad_pkg::CHECK_AT);
    pend    = hdr + ((dad_pkg::CMP_W'(dlen) + dad_pkg::CMP_W'(3)) & ~dad_pkg::CMP_W'(3));
    active  = (cur.err == dad_pkg::ST_OK) &&
              (cur.boff < dad_pkg::OFS_W'(dad_pkg::MAX_BUFFER_BYTES));

    if (active) begin
      // header field capture by byte position
      if (cur.nbytes == '0) begin
        nxt.vendor = '0;
      end
      if (cur.nbytes < dad_pkg::OFS_W'(4)) begin
        nxt.code = {cur.code[23:0], item.data_byte};
      end else if (cur.nbytes == dad_pkg::OFS_W'(4)) begin
        nxt.flags = item.data_byte;
      end else if (cur.nbytes < dad_pkg::OFS_W'(8)) begin
        nxt.len = {cur.len[15:0], item.data_byte};
      end else if (cur.nbytes < dad_pkg::OFS_W'(12) &&
                   (cur.flags & dad_pkg::VENDOR_BIT) != 8'h00) begin
        nxt.vendor = {cur.vendor[23:0], item.data_byte};
      end
      nxt.nbytes = n1;

      if (n1c >= dad_pkg::CMP_W'(dad_pkg::CHECK_AT)) begin
        // length checks, once per AVP
        if (n1c == dad_pkg::CMP_W'(dad_pkg::CHECK_AT)) begin
          if (cur.len == '0) begin
            nxt.err = dad_pkg::ST_ZERO_LEN;
          end else if (lenc < hdr) begin
            nxt.err = dad_pkg::ST_OVERRUN;
          end else if (lenc == hdr) begin
            nxt.err = dad_pkg::ST_EMPTY_DATA;
          end
        end
        if (nxt.err == dad_pkg::ST_OK) begin
          // report once the unpadded data is in
          if (n1c == done_at) begin
            emit            = 1'b1;
            res.has_avp     = 1'b1;
            res.attr_code   = cur.code;
            res.attr_flags  = dad_pkg::norm_flags(cur.code, cur.flags);
            res.vendor_id   = ((cur.flags & dad_pkg::VENDOR_BIT) != 8'h00) ?
                              nxt.vendor : 32'h0;
            res.data_offset = cur.start + hdr[15:0];
            res.data_len    = dlen;
          end
          // padding done: next byte opens a new AVP
          if (n1c >= pend) begin
            nxt.nbytes = '0;
            nxt.start  = 16'(cur.boff + 1'b1);
          end
        end
      end
      nxt.boff = cur.boff + 1'b1;
    end

    // final byte: status from what the buffer left behind, then clear
    nbc   = dad_pkg::CMP_W'(nxt.nbytes);
    nlenc = dad_pkg::CMP_W'(nxt.len);
    if (item.last_byte) begin
      res.buffer_end = 1'b1;
      if (nxt.err != dad_pkg::ST_OK) begin
        res.status = nxt.err;
      end else if (nbc >= dad_pkg::CMP_W'(1) && nbc < dad_pkg::CMP_W'(dad_pkg::CHECK_AT)) begin
        res.status = dad_pkg::ST_SHORT_HDR;
      end else if (nbc >= dad_pkg::CMP_W'(dad_pkg::CHECK_AT) && nbc < nlenc) begin
        res.status = dad_pkg::ST_OVERRUN;
      end
      nxt = '0;
    end

    res_valid = emit || item.last_byte;
  end

endmodule

### sv/diameter_avp_deframer_core.sv
// Grouped Diameter AVP deframer, top level: input register, parser state, result register.
// Depends on dad_pkg and dad_step.
`timescale 1ns / 1ps

// One buffer byte enters per item: the item sits in an
// input register, dad_step updates the parser state from it, and any result lands in an
// output register, so a new byte is taken each cycle unless a held result is stalled.
// A result passes through the input register and then the output register. A result comes out when an AVP's data
// is complete (code, normalized flags, vendor id, data offset and length) and on the
// final byte of the buffer, where status carries any error; both may share one result.
// The first error stops parsing until the final byte. After the final byte the parser
// is back at its reset state, ready for the next buffer.

module diameter_avp_deframer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dad_pkg::dad_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dad_pkg::dad_out_t out_data
);

  dad_pkg::dad_in_t    in_r;
  logic                in_valid_r;
  logic                in_valid_nxt;
  dad_pkg::dad_state_t st_r;
  dad_pkg::dad_state_t st_nxt;
  dad_pkg::dad_out_t   out_r;
  logic                out_valid_r;
  logic                out_valid_nxt;

  dad_pkg::dad_state_t step_state;
  dad_pkg::dad_out_t   step_res;
  logic                step_valid;
  logic                out_free;
  logic                proc;
  logic                in_take;

  dad_step u_step (
    .cur       (st_r),
    .item      (in_r),
    .nxt       (step_state),
    .res       (step_res),
    .res_valid (step_valid)
  );

  // handshake: the held item moves on whenever the result register can take it
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (proc) begin
      st_nxt        = step_state;
      out_valid_nxt = step_valid;
      in_valid_nxt  = 1'b0;
    end
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (proc && step_valid) begin
      out_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // an error status only ever rides on the end-of-buffer result
  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != dad_pkg::ST_OK |-> out_r.buffer_end)
    else $error("error status without buffer_end");

  // the final byte returns the parser to its reset state
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_r.last_byte |=> st_r.boff == '0 && st_r.nbytes == '0 &&
                               st_r.err == dad_pkg::ST_OK)
    else $error("parser state not cleared after final byte");

  // an AVP never holds more bytes than the buffer has delivered
  a_nbytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.nbytes <= st_r.boff)
    else $error("AVP byte count exceeds buffer offset");

  // errors are raised only at the length check and freeze the counters there
  a_err_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.err != dad_pkg::ST_OK |-> st_r.nbytes == dad_pkg::OFS_W'(dad_pkg::CHECK_AT))
    else $error("error latched away from the length check");

  // state moves only when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(st_r))
    else $error("parser state changed without an item");

endmodule
